FILE: hw/rtl/generation_snapshot_slot_store_core_macros.svh
// Assertion macros for the generation snapshot slot store.
// Used by the port checker; expects clk and rst in scope.
`ifndef GENERATION_SNAPSHOT_SLOT_STORE_CORE_MACROS_SVH
`define GENERATION_SNAPSHOT_SLOT_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/gss_pkg.sv
// Types, codes and helpers shared by the snapshot slot store and its checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

  localparam int GEN_W    = 32;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] RST_RING_SLOTS = 4'd4;
  localparam logic [CFG_W-1:0] RST_ITEM_BYTES = 4'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_CAPACITY  = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_STALE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_FREE      = 2'd0,
    PH_WRITING   = 2'd1,
    PH_PUBLISHED = 2'd2,
    PH_READING   = 2'd3
  } phase_t;

  typedef enum logic {
    CMD_PUBLISH = 1'b0,
    CMD_COPY    = 1'b1
  } command_t;

  typedef enum logic {
    REG_RING_SLOTS = 1'b0,
    REG_ITEM_BYTES = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EXEC,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic              command;
    logic [GEN_W-1:0]  generation;
    logic [LEN_W-1:0]  payload_length;
    logic [DATA_W-1:0] payload;
    logic              retire;
  } cmd_item_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
  } rsp_item_t;

  // Mask covering the low 'bytes' bytes of a data word.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] bytes);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if (LEN_W'(i) < bytes) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/generation_snapshot_slot_store_core.sv
// Generation snapshot slot store: top level, control sequencer and slot storage.
// Depends on gss_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A ring of snapshot slots tagged by generation. A publish item (command 0)
// stores its payload in slot (generation-1) mod the configured slot count when
// the generation is the expected next one and the slot is free, then marks the
// slot published and advances the expected generation (it sticks at 0 after the
// maximum, 2^GEN_BITS-1). A copy item (command 1) returns the slot data when the
// slot holds exactly the requested generation and is published; otherwise status
// is not ready (tag below request) or stale (tag above, or slot free). retire=1
// frees the slot on a good copy. Every item yields exactly one result item.
// Sequencing: an item with bad arguments (zero or out-of-range generation, length
// not equal to the configured payload size) goes from accept straight to the
// done state, which loads its result into the output register. Any other item
// runs through the bit-serial remainder unit, which reduces the 32-bit
// generation-1 by the slot count one bit per cycle, then a slot read state, an
// update state and the done state, then returns to idle for the next accept.
// The done state waits while the output register holds an untaken result.
// cmd_ready is high only while the sequencer is idle; a finished result sits in
// the output register so the next item can be accepted while the result still
// waits for rsp_ready. Configuration writes are always accepted and should
// only be issued while no item is in flight. No clearing pass after reset:
// slot phases and tag-written bits are flip-flops cleared at once.
module generation_snapshot_slot_store_core #(
  parameter int MAX_SLOTS         = 8,
  parameter int MAX_PAYLOAD_BYTES = 8,
  parameter int GEN_BITS          = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cmd_valid,
  output logic                        cmd_ready,
  input  gss_pkg::cmd_item_t          cmd,
  output logic                        rsp_valid,
  input  wire                         rsp_ready,
  output gss_pkg::rsp_item_t          rsp,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  gss_pkg::cfg_reg_t           cfg_index,
  input  wire [gss_pkg::CFG_W-1:0]    cfg_data
);

  localparam int SLOT_W  = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int REM_W   = SLOT_W + 1;
  localparam int TAG_W   = (GEN_BITS < gss_pkg::GEN_W) ? GEN_BITS : gss_pkg::GEN_W;
  localparam int CMP_W   = (GEN_BITS > gss_pkg::GEN_W) ? GEN_BITS : gss_pkg::GEN_W;
  localparam int STORE_W = MAX_PAYLOAD_BYTES * 8;
  localparam int CNT_W   = $clog2(gss_pkg::GEN_W);
  localparam logic [CMP_W-1:0] MAX_GEN = (CMP_W'(1) << GEN_BITS) - CMP_W'(1);

  // Sequencer and item registers
  gss_pkg::fsm_t                 state, state_next;
  gss_pkg::cmd_item_t            cur;
  logic [gss_pkg::GEN_W-1:0]     dvd;
  logic [REM_W-1:0]              rem;
  logic [CNT_W-1:0]              cnt;
  gss_pkg::status_t              res_status;
  logic [gss_pkg::DATA_W-1:0]    res_data;

  // Configuration and ring state
  logic [gss_pkg::CFG_W-1:0]     ring_slots;
  logic [gss_pkg::CFG_W-1:0]     item_bytes;
  logic [GEN_BITS-1:0]           expected;
  gss_pkg::phase_t               phase [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]          tag_written;
  logic [TAG_W-1:0]              tag_mem [MAX_SLOTS];
  logic [STORE_W-1:0]            data_mem [MAX_SLOTS];
  logic [TAG_W-1:0]              tag_rd;
  logic [STORE_W-1:0]            data_rd;

  // Combinational
  logic [SLOT_W-1:0]             eff_slots;
  logic [gss_pkg::LEN_W-1:0]     eff_bytes;
  logic [gss_pkg::DATA_W-1:0]    mask;
  logic                          arg_ok;
  logic                          cmd_fire;
  logic [REM_W-1:0]              shifted;
  logic [REM_W-1:0]              rem_next;
  logic [IDX_W-1:0]              idx;
  logic [gss_pkg::GEN_W-1:0]     cur_tag;
  gss_pkg::phase_t               cur_ph;
  gss_pkg::status_t              exec_status;
  logic [gss_pkg::DATA_W-1:0]    exec_data;
  logic                          pub_ok;
  logic                          copy_ok;
  logic [GEN_BITS-1:0]           expected_next;
  logic                          load_rsp;

  assign cfg_ready = 1'b1;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign mask      = gss_pkg::byte_mask(eff_bytes);
  assign idx       = rem[IDX_W-1:0];

  // Clamp the registers into their legal ranges at the point of use
  always_comb begin
    if (ring_slots == '0) begin
      eff_slots = SLOT_W'(1);
    end else if (int'(ring_slots) > MAX_SLOTS) begin
      eff_slots = SLOT_W'(MAX_SLOTS);
    end else begin
      eff_slots = SLOT_W'(ring_slots);
    end
    if (item_bytes == '0) begin
      eff_bytes = gss_pkg::LEN_W'(1);
    end else if (int'(item_bytes) > MAX_PAYLOAD_BYTES) begin
      eff_bytes = gss_pkg::LEN_W'(MAX_PAYLOAD_BYTES);
    end else begin
      eff_bytes = item_bytes;
    end
  end

  assign arg_ok = (cmd.payload_length == eff_bytes) && (cmd.generation != '0) &&
                  (CMP_W'(cmd.generation) <= MAX_GEN);

  // Remainder unit: shift in one dividend bit, subtract the slot count
  // when it fits.
  always_comb begin
    shifted  = {rem[REM_W-2:0], dvd[gss_pkg::GEN_W-1]};
    rem_next = (shifted >= REM_W'(eff_slots)) ? (shifted - REM_W'(eff_slots)) : shifted;
  end

  // Decide the item's outcome from the slot read in the previous cycle
  always_comb begin
    cur_tag       = tag_written[idx] ? gss_pkg::GEN_W'(tag_rd) : '0;
    cur_ph        = phase[idx];
    exec_status   = gss_pkg::ST_OK;
    exec_data     = '0;
    pub_ok        = 1'b0;
    copy_ok       = 1'b0;
    expected_next = expected;
    if (cur.command == gss_pkg::CMD_PUBLISH) begin
      if (CMP_W'(cur.generation) != CMP_W'(expected)) begin
        exec_status = gss_pkg::ST_INVALID;
      end else if (cur_ph != gss_pkg::PH_FREE) begin
        exec_status = gss_pkg::ST_CAPACITY;
      end else begin
        pub_ok        = 1'b1;
        expected_next = (CMP_W'(cur.generation) == MAX_GEN) ? '0 :
                        GEN_BITS'(CMP_W'(cur.generation) + CMP_W'(1));
      end
    end else begin
      if (cur_tag < cur.generation ||
          (cur_tag == cur.generation && cur_ph == gss_pkg::PH_WRITING)) begin
        exec_status = gss_pkg::ST_NOT_READY;
      end else if (cur_tag > cur.generation || cur_ph == gss_pkg::PH_FREE) begin
        exec_status = gss_pkg::ST_STALE;
      end else if (cur_ph != gss_pkg::PH_PUBLISHED) begin
        exec_status = gss_pkg::ST_NOT_READY;
      end else begin
        copy_ok   = 1'b1;
        exec_data = gss_pkg::DATA_W'(data_rd) & mask;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      gss_pkg::S_IDLE: begin
        if (cmd_fire) state_next = arg_ok ? gss_pkg::S_DIV : gss_pkg::S_DONE;
      end
      gss_pkg::S_DIV: begin
        if (cnt == CNT_W'(gss_pkg::GEN_W - 1)) state_next = gss_pkg::S_READ;
      end
      gss_pkg::S_READ: state_next = gss_pkg::S_EXEC;
      gss_pkg::S_EXEC: state_next = gss_pkg::S_DONE;
      gss_pkg::S_DONE: begin
        if (load_rsp) state_next = gss_pkg::S_IDLE;
      end
      default: state_next = gss_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_ready = (state == gss_pkg::S_IDLE);
    load_rsp  = (state == gss_pkg::S_DONE) && (!rsp_valid || rsp_ready);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gss_pkg::S_IDLE;
      rsp_valid   <= 1'b0;
      ring_slots  <= gss_pkg::RST_RING_SLOTS;
      item_bytes  <= gss_pkg::RST_ITEM_BYTES;
      expected    <= GEN_BITS'(1);
      tag_written <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) phase[i] <= gss_pkg::PH_FREE;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gss_pkg::REG_RING_SLOTS: ring_slots <= cfg_data;
          gss_pkg::REG_ITEM_BYTES: item_bytes <= cfg_data;
          default: ;
        endcase
      end
      if (state == gss_pkg::S_EXEC) begin
        if (pub_ok) begin
          phase[idx]       <= gss_pkg::PH_PUBLISHED;
          tag_written[idx] <= 1'b1;
          expected         <= expected_next;
        end else if (copy_ok && cur.retire) begin
          phase[idx] <= gss_pkg::PH_FREE;
        end
      end
    end
  end

  // Datapath: item capture, remainder iterations, result and output registers
  always_ff @(posedge clk) begin
    case (state)
      gss_pkg::S_IDLE: begin
        if (cmd_fire) begin
          cur        <= cmd;
          dvd        <= cmd.generation - gss_pkg::GEN_W'(1);
          rem        <= '0;
          cnt        <= '0;
          res_status <= gss_pkg::ST_INVALID;
          res_data   <= '0;
        end
      end
      gss_pkg::S_DIV: begin
        rem <= rem_next;
        dvd <= {dvd[gss_pkg::GEN_W-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
      end
      gss_pkg::S_EXEC: begin
        res_status <= exec_status;
        res_data   <= exec_data;
      end
      default: ;
    endcase
    if (load_rsp) begin
      rsp.status <= res_status;
      rsp.data   <= res_data;
    end
  end

  // Slot memories: read at the slot index in the read cycle, write on publish
  always_ff @(posedge clk) begin
    if (state == gss_pkg::S_READ) begin
      tag_rd  <= tag_mem[idx];
      data_rd <= data_mem[idx];
    end
    if (state == gss_pkg::S_EXEC && pub_ok) begin
      tag_mem[idx]  <= TAG_W'(cur.generation);
      data_mem[idx] <= STORE_W'(cur.payload & mask);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gss_checker.sv
// Port-level checker for the generation snapshot slot store, bound to the top.
// Depends on gss_pkg and generation_snapshot_slot_store_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "generation_snapshot_slot_store_core_macros.svh"

module gss_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 cmd_valid,
  input wire                 cmd_ready,
  input wire                 rsp_valid,
  input wire                 rsp_ready,
  input gss_pkg::rsp_item_t  rsp
);

  // Hold a stalled result item
  `GSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

  // One item at a time: busy right after an accept
  `GSS_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "accepted a second item while busy")

  // Only a good result carries data
  `GSS_ASSERT_NOW(a_data_zero_on_error, rsp_valid && rsp.status != gss_pkg::ST_OK, rsp.data == '0, "nonzero data on failed item")

endmodule

bind generation_snapshot_slot_store_core gss_checker u_gss_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for generation_snapshot_slot_store_core.
// Depends on gss_pkg and the core; predicts every result item and checks it in order.
`timescale 1ns / 1ps

module tb_top;

  localparam int RING_DEPTH = 8;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 315;

  // Predictor of the slot ring plus the queue of results it still owes.
  class slot_ring_scoreboard;
    logic [gss_pkg::GEN_W-1:0]  tag_of [RING_DEPTH];
    gss_pkg::phase_t            phase_of [RING_DEPTH];
    logic [gss_pkg::DATA_W-1:0] word_of [RING_DEPTH];
    logic [gss_pkg::GEN_W-1:0]  next_gen;
    logic [gss_pkg::CFG_W-1:0]  slots_reg;
    logic [gss_pkg::CFG_W-1:0]  size_reg;
    gss_pkg::rsp_item_t         owed_answers[$];
    int                         errors;

    function new();
      for (int i = 0; i < RING_DEPTH; i++) begin
        tag_of[i]   = '0;
        phase_of[i] = gss_pkg::PH_FREE;
        word_of[i]  = '0;
      end
      next_gen  = 32'd1;
      slots_reg = gss_pkg::RST_RING_SLOTS;
      size_reg  = gss_pkg::RST_ITEM_BYTES;
      errors    = 0;
    endfunction

    // Out-of-range register values clamp when used.
    function int unsigned ring_slots();
      if (slots_reg < 1) return 1;
      if (slots_reg > RING_DEPTH) return RING_DEPTH;
      return slots_reg;
    endfunction

    function int unsigned item_bytes();
      if (size_reg < 1) return 1;
      if (size_reg > gss_pkg::DATA_W / 8) return gss_pkg::DATA_W / 8;
      return size_reg;
    endfunction

    function logic [gss_pkg::DATA_W-1:0] low_bytes(int unsigned n);
      if (n >= gss_pkg::DATA_W / 8) return '1;
      return (64'd1 << (n * 8)) - 64'd1;
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction

    function void write_register(gss_pkg::cfg_reg_t idx, logic [gss_pkg::CFG_W-1:0] value);
      if (idx == gss_pkg::REG_RING_SLOTS) slots_reg = value;
      else size_reg = value;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    // Work out the answer to an accepted request and advance the ring.
    function void note_request(gss_pkg::cmd_item_t req);
      gss_pkg::rsp_item_t        ans;
      int unsigned               slots;
      int unsigned               bytes;
      int unsigned               idx;
      logic [gss_pkg::GEN_W-1:0] tag;
      gss_pkg::phase_t           ph;
      ans.status = gss_pkg::ST_OK;
      ans.data   = '0;
      slots = ring_slots();
      bytes = item_bytes();
      if (int'(req.payload_length) != bytes || req.generation == '0) begin
        ans.status = gss_pkg::ST_INVALID;
      end else begin
        idx = (req.generation - 32'd1) % slots;
        if (req.command == gss_pkg::CMD_PUBLISH) begin
          if (req.generation != next_gen) begin
            ans.status = gss_pkg::ST_INVALID;
          end else if (phase_of[idx] != gss_pkg::PH_FREE) begin
            ans.status = gss_pkg::ST_CAPACITY;
          end else begin
            word_of[idx]  = req.payload & low_bytes(bytes);
            tag_of[idx]   = req.generation;
            phase_of[idx] = gss_pkg::PH_PUBLISHED;
            // Generations run out after the all-ones value.
            next_gen = (req.generation == '1) ? '0 : req.generation + 32'd1;
          end
        end else begin
          tag = tag_of[idx];
          ph  = phase_of[idx];
          if (tag < req.generation ||
              (tag == req.generation && ph == gss_pkg::PH_WRITING)) begin
            ans.status = gss_pkg::ST_NOT_READY;
          end else if (tag > req.generation || ph == gss_pkg::PH_FREE) begin
            ans.status = gss_pkg::ST_STALE;
          end else if (ph != gss_pkg::PH_PUBLISHED) begin
            ans.status = gss_pkg::ST_NOT_READY;
          end else begin
            ans.data      = word_of[idx] & low_bytes(bytes);
            phase_of[idx] = req.retire ? gss_pkg::PH_FREE : gss_pkg::PH_PUBLISHED;
          end
        end
      end
      owed_answers = {owed_answers, ans};
    endfunction

    task check_answer(gss_pkg::rsp_item_t got);
      gss_pkg::rsp_item_t want;
      if (owed_answers.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d data %h",
                                  got.status, got.data));
      end else begin
        want = owed_answers.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.data !== want.data)
          report_mismatch($sformatf("data %h, expected %h", got.data, want.data));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_ready;
  gss_pkg::cmd_item_t         cmd = '0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  gss_pkg::rsp_item_t         rsp;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  gss_pkg::cfg_reg_t          cfg_index = gss_pkg::REG_RING_SLOTS;
  logic [gss_pkg::CFG_W-1:0]  cfg_data = '0;

  int                         snd_idle_pct = 27;
  int                         rcv_idle_pct = 59;
  slot_ring_scoreboard        sb;

  generation_snapshot_slot_store_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: check the item taken at this edge, then pick next cycle's ready.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_answer(rsp);
    rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Offer one item, with a random gap first, and hold it until taken.
  task automatic send_item(gss_pkg::cmd_item_t it);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd       <= it;
    do @(posedge clk); while (!cmd_ready);
    sb.note_request(it);
  endtask

  task automatic send_fields(gss_pkg::command_t c, logic [gss_pkg::GEN_W-1:0] g,
                             logic [gss_pkg::LEN_W-1:0] l,
                             logic [gss_pkg::DATA_W-1:0] p, logic r);
    gss_pkg::cmd_item_t it;
    it.command        = c;
    it.generation     = g;
    it.payload_length = l;
    it.payload        = p;
    it.retire         = r;
    send_item(it);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(gss_pkg::cfg_reg_t idx, logic [gss_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic around the expected generation, plus noise.
  function automatic gss_pkg::cmd_item_t random_request();
    gss_pkg::cmd_item_t        it;
    int unsigned               pick;
    int unsigned               slots;
    logic [gss_pkg::GEN_W-1:0] nxt;
    pick  = $urandom_range(0, 99);
    slots = sb.ring_slots();
    nxt   = sb.next_gen;
    it.command        = gss_pkg::CMD_PUBLISH;
    it.generation     = nxt;
    it.payload_length = gss_pkg::LEN_W'(sb.item_bytes());
    it.payload        = {$urandom, $urandom};
    it.retire         = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      // publish the expected generation
    end else if (pick < 75) begin
      it.command    = gss_pkg::CMD_COPY;
      it.generation = nxt - 32'd1 - $urandom_range(0, slots);
    end else if (pick < 82) begin
      it.command    = gss_pkg::CMD_COPY;
      it.generation = $urandom_range(0, 1) ? nxt + $urandom_range(0, 2)
                                           : nxt - 32'd1 - $urandom_range(0, 3 * slots);
    end else if (pick < 88) begin
      it.generation = $urandom_range(0, 1) ? nxt + $urandom_range(1, 3)
                                           : nxt - $urandom_range(1, slots);
    end else if (pick < 94) begin
      it.command        = gss_pkg::command_t'($urandom_range(0, 1));
      it.generation     = nxt - $urandom_range(0, slots);
      it.payload_length = gss_pkg::LEN_W'($urandom_range(0, 15));
    end else begin
      it.command        = gss_pkg::command_t'($urandom_range(0, 1));
      it.generation     = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      it.payload_length = gss_pkg::LEN_W'($urandom_range(0, 15));
    end
    return it;
  endfunction

  initial begin
    logic [gss_pkg::CFG_W-1:0] slot_set [PHASES];
    logic [gss_pkg::CFG_W-1:0] size_set [PHASES];
    sb = new();
    // Extremes first, then values outside 1..8 that must clamp, then mid and random.
    slot_set = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd0};
    size_set = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd5, 4'd0};
    slot_set[PHASES-1] = gss_pkg::CFG_W'($urandom_range(1, 8));
    size_set[PHASES-1] = gss_pkg::CFG_W'($urandom_range(1, 8));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass at reset settings: 4 slots, 8-byte payloads.
    send_fields(gss_pkg::CMD_COPY,    32'd1,        4'd8, '0, 1'b0); // nothing published
    send_fields(gss_pkg::CMD_PUBLISH, 32'd0,        4'd8, '1, 1'b0); // zero generation
    send_fields(gss_pkg::CMD_PUBLISH, 32'd1,        4'd7, '1, 1'b0); // length mismatch
    send_fields(gss_pkg::CMD_PUBLISH, 32'd2,        4'd8, '1, 1'b0); // not the expected one
    send_fields(gss_pkg::CMD_PUBLISH, 32'd1,        4'd8, '1, 1'b0);
    send_fields(gss_pkg::CMD_PUBLISH, 32'hFFFFFFFF, 4'd8, '1, 1'b1);
    send_fields(gss_pkg::CMD_COPY,    32'd1,        4'd8, '0, 1'b0); // retain
    send_fields(gss_pkg::CMD_COPY,    32'd1,        4'd15, '0, 1'b0);
    send_fields(gss_pkg::CMD_PUBLISH, 32'd2,        4'd8, '0, 1'b1); // retire ignored
    send_fields(gss_pkg::CMD_PUBLISH, 32'd3,        4'd8, 64'hAAAAAAAAAAAAAAAA, 1'b0);
    send_fields(gss_pkg::CMD_PUBLISH, 32'd4,        4'd8, 64'h5555555555555555, 1'b0);
    send_fields(gss_pkg::CMD_PUBLISH, 32'd5,        4'd8, '1, 1'b0); // slot still held
    send_fields(gss_pkg::CMD_COPY,    32'd5,        4'd8, '0, 1'b0); // tag below request
    send_fields(gss_pkg::CMD_COPY,    32'd1,        4'd8, '0, 1'b1); // retire frees it
    send_fields(gss_pkg::CMD_COPY,    32'd1,        4'd8, '0, 1'b0); // same tag, free slot
    send_fields(gss_pkg::CMD_PUBLISH, 32'd5,        4'd8, 64'h0123456789ABCDEF, 1'b0);
    send_fields(gss_pkg::CMD_COPY,    32'd1,        4'd8, '0, 1'b0); // tag above request
    send_fields(gss_pkg::CMD_COPY,    32'hFFFFFFFF, 4'd8, '0, 1'b1);
    send_fields(gss_pkg::CMD_COPY,    32'd0,        4'd8, '0, 1'b0);
    send_fields(gss_pkg::CMD_COPY,    32'd5,        4'd8, '0, 1'b1);
    send_fields(gss_pkg::CMD_COPY,    32'h80000000, 4'd8, '0, 1'b0);
    send_fields(gss_pkg::CMD_PUBLISH, 32'd6,        4'd8, 64'hFEDCBA9876543210, 1'b0);
    send_fields(gss_pkg::CMD_COPY,    32'd2,        4'd8, '0, 1'b0);
    drain_results();

    // Random phases; slot state carries across register changes.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        snd_idle_pct = 27;
        rcv_idle_pct = 59;
      end else if (ph < 4) begin
        snd_idle_pct = 59;
        rcv_idle_pct = 27;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_register(gss_pkg::REG_RING_SLOTS, slot_set[ph]);
      write_register(gss_pkg::REG_ITEM_BYTES, size_set[ph]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Hold off now and then until the block has answered everything.
        if (n == PHASE_LEN / 2 || $urandom_range(0, 199) == 0) drain_results();
        send_item(random_request());
      end
      drain_results();
    end

    // Catch any stray result after the last expected one.
    repeat (60) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results still expected at end of run");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout waiting on the block");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
